// ----- rtl/core/cdd_pkg.sv -----
// Shared types, codes and sizing constants for the cloud-in-cell density deposit block.
package cdd_pkg;

    localparam int GRID_MAX = 32;
    localparam int CELLS    = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int COORD_W  = $clog2(GRID_MAX);
    localparam int SIZE_W   = $clog2(GRID_MAX + 1);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int DATA_W   = 32;
    localparam int WEIGHT_W = 17;
    localparam int ONE_Q16  = 65536;

    typedef enum logic [1:0] {
        CMD_DEPOSIT    = 2'd0,
        CMD_READ       = 2'd1,
        CMD_READ_CLEAR = 2'd2,
        CMD_NONE       = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_DROP = 2'd1,
        STS_SAT  = 2'd2,
        STS_OOB  = 2'd3
    } status_code_t;

    typedef enum logic {
        REG_GRID_SIZE  = 1'b0,
        REG_GRID_SCALE = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_AXIS,
        S_CELLS,
        S_DRAIN,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       clear_step;
        logic       axis_mul;
        logic       axis_proc;
        logic [1:0] axis_idx;
        logic       cell_issue;
        logic [2:0] cell_idx;
        logic       read_issue;
        logic       read_capture;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_deposit;
        logic is_read;
        logic read_oob;
        logic drop;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
        logic [ADDR_W+COORD_W:0] a;
        a = (ADDR_W+COORD_W+1)'(x) * (ADDR_W+COORD_W+1)'(GRID_MAX);
        a = (a + (ADDR_W+COORD_W+1)'(y)) * (ADDR_W+COORD_W+1)'(GRID_MAX);
        a = a + (ADDR_W+COORD_W+1)'(z);
        return a[ADDR_W-1:0];
    endfunction

endpackage

// ----- rtl/core/cic_density_deposit.sv -----
// Cloud-in-cell density deposit: top level joining the sequencer and the datapath.
// A deposit request scales each position coordinate by grid_scale, finds the nearest node
// and its periodic neighbor per axis, and adds the eight trilinear weight products into a
// 32768-word grid memory with saturating adds. A deposit passes through a dispatch state,
// the three per-axis scaling multiplies, the eight read-modify-write updates issued one
// per cycle into the memory's single write port, a drain of the update pipeline and the
// load of the result register. The block takes no new request until the previous one has
// been loaded into the result register. Reads outside the grid and the unused command go
// straight from dispatch to the result; deposits for a position outside the box are dropped
// after the axis scaling. After reset the block clears the grid, one word a cycle, and
// holds in_stall high during that pass. Only one request is in flight at a time, but a
// finished result may sit in the output register while the next request is accepted;
// while the output register is full and stalled, a finished request waits.
// Configuration must only be written while the block is idle.
module cic_density_deposit
    import cdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [4:0]  read_x,
    input  logic [4:0]  read_y,
    input  logic [4:0]  read_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] cell_value,
    output logic [1:0]  status
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    // The sequencer owns all handshake state.
    cdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds configuration, arithmetic, the grid memory and the result payload.
    cdd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .read_x       (read_x),
        .read_y       (read_y),
        .read_z       (read_z),
        .cmd          (cmd),
        .sts          (sts),
        .cell_value   (cell_value),
        .status       (status)
    );

endmodule

// ----- rtl/core/cdd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/cdd_ctrl.sv -----
// Sequencing state machine for clearing, deposits, reads and result hand-off.
module cdd_ctrl
    import cdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cnt_next = '0;
                if (sts.is_deposit)
                begin
                    state_next = S_AXIS;
                end
                else if (sts.is_read && !sts.read_oob)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_AXIS:
            begin
                if (cnt_reg == 3'd3)
                begin
                    cnt_next   = '0;
                    state_next = S_CELLS;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_CELLS:
            begin
                if (sts.drop)
                begin
                    state_next = S_DONE;
                end
                else if (cnt_reg == 3'd7)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg == 3'd1)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_READ:      state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        cmd.axis_idx   = cnt_reg[1:0];
        cmd.cell_idx   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:     cmd.clear_step = 1'b1;
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_DISPATCH:  ;
            S_AXIS:
            begin
                cmd.axis_mul  = (cnt_reg != 3'd3);
                cmd.axis_proc = (cnt_reg != 3'd0);
            end
            S_CELLS:     cmd.cell_issue = !sts.drop;
            S_DRAIN:     ;
            S_READ:      cmd.read_issue = 1'b1;
            S_READ_WAIT: cmd.read_capture = 1'b1;
            S_DONE:      cmd.out_load = !out_valid_reg || !out_stall;
            default:     ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/cdd_datapath.sv -----
// Datapath: configuration, position scaling, weights, grid memory updates and result register.
module cdd_datapath
    import cdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic [1:0]         command,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  logic [4:0]         read_x,
    input  logic [4:0]         read_y,
    input  logic [4:0]         read_z,
    input  dp_cmd_t            cmd,
    output dp_status_t         sts,
    output logic [31:0]        cell_value,
    output logic [1:0]         status
);

    logic [5:0]  grid_size_reg;
    logic [31:0] grid_scale_reg;
    logic [SIZE_W-1:0] n;

    logic [1:0]  cmd_reg;
    logic [31:0] pos_reg [3];
    logic [4:0]  rx_reg, ry_reg, rz_reg;

    logic [47:0] u_reg;
    logic [COORD_W-1:0]  node_reg [3];
    logic [COORD_W-1:0]  nb_reg   [3];
    logic [WEIGHT_W-1:0] wa_reg   [3];
    logic [WEIGHT_W-1:0] wb_reg   [3];
    logic drop_reg, sat_reg;

    logic [ADDR_W-1:0] clr_addr_reg;

    logic                s1_v_reg, s2_v_reg;
    logic [2*WEIGHT_W-1:0] pxy_reg;
    logic [WEIGHT_W-1:0] wz_s1_reg;
    logic [ADDR_W-1:0]   addr_s1_reg, addr_s2_reg;
    logic [WEIGHT_W-1:0] p_reg;
    logic [31:0]         rdval_reg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr, rd_addr;
    logic [DATA_W-1:0]   ram_wdata, ram_rdata;

    logic        read_oob;
    logic [1:0]  proc_idx;
    logic [31:0] pos_sel;
    logic [63:0] prod;
    logic [SIZE_W:0] c, c1;
    logic        up;
    logic [15:0] ad;
    logic [COORD_W-1:0] node_c, nb_c;
    logic [WEIGHT_W-1:0] wx, wy, wz;
    logic [ADDR_W-1:0] cell_a;
    logic [3*WEIGHT_W-1+2:0] p51;
    logic [32:0] sum;

    // Effective grid size clamped to the built range.
    always_comb
    begin
        if (grid_size_reg < 6'd2)
        begin
            n = SIZE_W'(2);
        end
        else if (32'(grid_size_reg) > GRID_MAX)
        begin
            n = SIZE_W'(GRID_MAX);
        end
        else
        begin
            n = SIZE_W'(grid_size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= 6'd32;
            grid_scale_reg <= 32'd65536;
        end
        else if (cfg_write_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GRID_SIZE:  grid_size_reg  <= cfg_data[5:0];
                REG_GRID_SCALE: grid_scale_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            rx_reg     <= read_x;
            ry_reg     <= read_y;
            rz_reg     <= read_z;
        end
    end

    assign read_oob = (32'(rx_reg) >= 32'(n)) || (32'(ry_reg) >= 32'(n))
                   || (32'(rz_reg) >= 32'(n));

    assign sts.is_deposit = (cmd_code_t'(cmd_reg) == CMD_DEPOSIT);
    assign sts.is_read    = (cmd_code_t'(cmd_reg) == CMD_READ)
                         || (cmd_code_t'(cmd_reg) == CMD_READ_CLEAR);
    assign sts.read_oob   = read_oob;
    assign sts.drop       = drop_reg;
    assign sts.clear_last = (clr_addr_reg == ADDR_W'(CELLS - 1));

    // Axis scaling: one multiply per axis, processed the following cycle.
    always_comb
    begin
        case (cmd.axis_idx)
            2'd0:    pos_sel = pos_reg[0];
            2'd1:    pos_sel = pos_reg[1];
            2'd2:    pos_sel = pos_reg[2];
            default: pos_sel = '0;
        endcase
    end

    assign prod     = 64'(pos_sel) * 64'(grid_scale_reg);
    assign proc_idx = cmd.axis_idx - 2'd1;

    // Nearest node, offset magnitude and wrapped neighbor for one axis.
    always_comb
    begin
        up = u_reg[15];
        c  = (SIZE_W+1)'(u_reg[16 +: SIZE_W]) + (SIZE_W+1)'(up);
        ad = up ? 16'(17'(ONE_Q16) - 17'(u_reg[15:0])) : u_reg[15:0];
        c1 = c + (SIZE_W+1)'(1);
        if (!up && (u_reg[15:0] != 16'd0))
        begin
            nb_c = (c1 >= (SIZE_W+1)'(n)) ? COORD_W'(c1 - (SIZE_W+1)'(n)) : COORD_W'(c1);
        end
        else
        begin
            nb_c = (c == '0) ? COORD_W'(n - SIZE_W'(1)) : COORD_W'(c - (SIZE_W+1)'(1));
        end
        node_c = (c >= (SIZE_W+1)'(n)) ? COORD_W'(c - (SIZE_W+1)'(n)) : COORD_W'(c);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.axis_mul)
        begin
            u_reg <= prod[63:16];
        end
        if (cmd.axis_proc && (proc_idx != 2'd3))
        begin
            node_reg[proc_idx] <= node_c;
            nb_reg[proc_idx]   <= nb_c;
            wa_reg[proc_idx]   <= WEIGHT_W'(ONE_Q16) - WEIGHT_W'(ad);
            wb_reg[proc_idx]   <= WEIGHT_W'(ad);
        end
    end

    // Drop and saturation flags live for one request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            drop_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.axis_proc && (u_reg[47:16] >= 32'(n)))
            begin
                drop_reg <= 1'b1;
            end
            if (s2_v_reg && sum[32])
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    // Cell update pipeline: weights, product, then read-modify-write.
    assign wx = cmd.cell_idx[2] ? wb_reg[0] : wa_reg[0];
    assign wy = cmd.cell_idx[1] ? wb_reg[1] : wa_reg[1];
    assign wz = cmd.cell_idx[0] ? wb_reg[2] : wa_reg[2];
    assign cell_a = cell_addr(cmd.cell_idx[2] ? nb_reg[0] : node_reg[0],
                              cmd.cell_idx[1] ? nb_reg[1] : node_reg[1],
                              cmd.cell_idx[0] ? nb_reg[2] : node_reg[2]);

    assign p51 = ((3*WEIGHT_W+2)'(pxy_reg) * (3*WEIGHT_W+2)'(wz_s1_reg))
               + (3*WEIGHT_W+2)'(64'h8000_0000);
    assign sum = 33'(ram_rdata) + 33'(p_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            s1_v_reg <= cmd.cell_issue;
            s2_v_reg <= s1_v_reg;
            if (cmd.clear_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pxy_reg     <= (2*WEIGHT_W)'(wx) * (2*WEIGHT_W)'(wy);
        wz_s1_reg   <= wz;
        addr_s1_reg <= cell_a;
        p_reg       <= p51[32 +: WEIGHT_W];
        addr_s2_reg <= addr_s1_reg;
        if (cmd.read_capture)
        begin
            rdval_reg <= ram_rdata;
        end
    end

    // Memory port selection.
    assign rd_addr = cell_addr(COORD_W'(rx_reg), COORD_W'(ry_reg), COORD_W'(rz_reg));

    always_comb
    begin
        ram_raddr = cmd.read_issue ? rd_addr : addr_s1_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_s2_reg;
        ram_wdata = sum[32] ? {DATA_W{1'b1}} : sum[31:0];
        if (cmd.clear_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.read_capture)
        begin
            ram_we    = (cmd_code_t'(cmd_reg) == CMD_READ_CLEAR);
            ram_waddr = rd_addr;
            ram_wdata = '0;
        end
        else if (s2_v_reg)
        begin
            ram_we = 1'b1;
        end
    end

    cdd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd_code_t'(cmd_reg)) inside
                CMD_DEPOSIT:
                begin
                    cell_value <= '0;
                    status     <= drop_reg ? STS_DROP : (sat_reg ? STS_SAT : STS_OK);
                end
                CMD_READ, CMD_READ_CLEAR:
                begin
                    cell_value <= read_oob ? 32'd0 : rdval_reg;
                    status     <= read_oob ? STS_OOB : STS_OK;
                end
                default:
                begin
                    cell_value <= '0;
                    status     <= STS_OK;
                end
            endcase
        end
    end

endmodule
